>>> rtl/eatrm_pkg.sv
// ----------------------------------------------------------------------------
// eatrm_pkg
// Types, constants and helpers shared by the Euler angle to DCM unit.
// ----------------------------------------------------------------------------
package eatrm_pkg;

  localparam int ITER_COUNT = 18;
  localparam int XY_W       = 32;  // CORDIC x/y, Q30
  localparam int Z_W        = 26;  // CORDIC residual angle, 2^24 per turn
  localparam int TRIG_W     = 26;  // sine/cosine, Q24
  localparam int MIX_W      = 28;  // rounded double product, Q24
  localparam int SUM_W      = 56;  // entry sum, Q48

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_q24;
    logic signed [TRIG_W-1:0] sin_q24;
  } trig_t;

  // atan(2^-i) in 2^24 units per turn
  function automatic logic signed [Z_W-1:0] atan_q24(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:       r = 26'sd2097152;
      1:       r = 26'sd1238021;
      2:       r = 26'sd654136;
      3:       r = 26'sd332050;
      4:       r = 26'sd166669;
      5:       r = 26'sd83416;
      6:       r = 26'sd41718;
      7:       r = 26'sd20860;
      8:       r = 26'sd10430;
      9:       r = 26'sd5215;
      10:      r = 26'sd2608;
      11:      r = 26'sd1304;
      12:      r = 26'sd652;
      13:      r = 26'sd326;
      14:      r = 26'sd163;
      15:      r = 26'sd81;
      16:      r = 26'sd41;
      17:      r = 26'sd20;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q48 to Q14, round half up, saturate to +/- 1.0
  function automatic logic signed [15:0] to_q14(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    logic signed [15:0]      q;
    r = (v + (SUM_W'(1) <<< 33)) >>> 34;
    if (r > SUM_W'(16384))
      q = 16'sd16384;
    else if (r < -SUM_W'(16384))
      q = -16'sd16384;
    else
      q = r[15:0];
    return q;
  endfunction

endpackage

>>> rtl/eatrm_cordic.sv
// ----------------------------------------------------------------------------
// eatrm_cordic
// Rotation-mode CORDIC, one register stage per iteration plus rounding stage.
// ----------------------------------------------------------------------------
module eatrm_cordic (
  input  logic                clk,
  input  logic signed [15:0]  angle,
  output eatrm_pkg::trig_t    trig
);

  localparam int N  = eatrm_pkg::ITER_COUNT;
  localparam int XW = eatrm_pkg::XY_W;
  localparam int ZW = eatrm_pkg::Z_W;
  localparam int TW = eatrm_pkg::TRIG_W;

  logic signed [XW-1:0] xs [N];
  logic signed [XW-1:0] ys [N];
  logic signed [ZW-1:0] zs [N];
  logic                 flp [N];

  // quadrant fold: outside +/- pi/2 shift by pi and negate later
  logic                 fold;
  logic signed [15:0]   a_red;
  assign fold  = angle[15] ^ angle[14];
  assign a_red = {angle[15] ^ fold, angle[14:0]};

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      logic signed [XW-1:0] x_in, y_in;
      logic signed [ZW-1:0] z_in;
      logic                 f_in;
      if (i == 0) begin : g_first
        assign x_in = eatrm_pkg::CORDIC_GAIN;
        assign y_in = '0;
        assign z_in = ZW'(a_red) <<< 8;
        assign f_in = fold;
      end else begin : g_next
        assign x_in = xs[i-1];
        assign y_in = ys[i-1];
        assign z_in = zs[i-1];
        assign f_in = flp[i-1];
      end
      always_ff @(posedge clk) begin
        if (!z_in[ZW-1]) begin
          xs[i] <= x_in - (y_in >>> i);
          ys[i] <= y_in + (x_in >>> i);
          zs[i] <= z_in - eatrm_pkg::atan_q24(i);
        end else begin
          xs[i] <= x_in + (y_in >>> i);
          ys[i] <= y_in - (x_in >>> i);
          zs[i] <= z_in + eatrm_pkg::atan_q24(i);
        end
        flp[i] <= f_in;
      end
    end
  endgenerate

  // Q30 to Q24 with rounding, then undo the fold
  logic signed [XW-1:0] xr, yr;
  assign xr = (xs[N-1] + XW'(32)) >>> 6;
  assign yr = (ys[N-1] + XW'(32)) >>> 6;

  always_ff @(posedge clk) begin
    if (flp[N-1]) begin
      trig.cos_q24 <= -xr[TW-1:0];
      trig.sin_q24 <= -yr[TW-1:0];
    end else begin
      trig.cos_q24 <= xr[TW-1:0];
      trig.sin_q24 <= yr[TW-1:0];
    end
  end

endmodule

>>> rtl/eatrm_matrix.sv
// ----------------------------------------------------------------------------
// eatrm_matrix
// Products, rounding and sums of the nine DCM entries over four stages.
// ----------------------------------------------------------------------------
module eatrm_matrix (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  eatrm_pkg::trig_t  roll,
  input  eatrm_pkg::trig_t  pitch,
  input  eatrm_pkg::trig_t  yaw,
  output logic              done,
  output eatrm_pkg::out_t   result
);

  localparam int TW = eatrm_pkg::TRIG_W;
  localparam int MW = eatrm_pkg::MIX_W;
  localparam int SW = eatrm_pkg::SUM_W;
  localparam int PW = 2 * TW;
  localparam int QW = TW + MW;

  logic [2:0] vld;

  // stage 1: two-term products
  logic signed [PW-1:0] spcy1, spsy1, cpcy1, cpsy1, srcp1, crcp1;
  logic signed [PW-1:0] crsy1, srsy1, crcy1, srcy1;
  logic signed [TW-1:0] cr1, sr1, sp1;
  // stage 2: round the pitch-yaw products
  logic signed [MW-1:0] spcy2, spsy2;
  logic signed [PW-1:0] cpcy2, cpsy2, srcp2, crcp2, crsy2, srsy2, crcy2, srcy2;
  logic signed [TW-1:0] cr2, sr2, sp2;
  // stage 3: triple products
  logic signed [QW-1:0] a3, b3, c3, d3;
  logic signed [PW-1:0] cpcy3, cpsy3, srcp3, crcp3, crsy3, srsy3, crcy3, srcy3;
  logic signed [TW-1:0] sp3;

  logic signed [PW-1:0] spcy_r, spsy_r;
  assign spcy_r = (spcy1 + (PW'(1) <<< 23)) >>> 24;
  assign spsy_r = (spsy1 + (PW'(1) <<< 23)) >>> 24;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[1:0], in_vld};
      done <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    spcy1 <= pitch.sin_q24 * yaw.cos_q24;
    spsy1 <= pitch.sin_q24 * yaw.sin_q24;
    cpcy1 <= pitch.cos_q24 * yaw.cos_q24;
    cpsy1 <= pitch.cos_q24 * yaw.sin_q24;
    srcp1 <= roll.sin_q24  * pitch.cos_q24;
    crcp1 <= roll.cos_q24  * pitch.cos_q24;
    crsy1 <= roll.cos_q24  * yaw.sin_q24;
    srsy1 <= roll.sin_q24  * yaw.sin_q24;
    crcy1 <= roll.cos_q24  * yaw.cos_q24;
    srcy1 <= roll.sin_q24  * yaw.cos_q24;
    cr1   <= roll.cos_q24;
    sr1   <= roll.sin_q24;
    sp1   <= pitch.sin_q24;

    spcy2 <= spcy_r[MW-1:0];
    spsy2 <= spsy_r[MW-1:0];
    cpcy2 <= cpcy1; cpsy2 <= cpsy1; srcp2 <= srcp1; crcp2 <= crcp1;
    crsy2 <= crsy1; srsy2 <= srsy1; crcy2 <= crcy1; srcy2 <= srcy1;
    cr2   <= cr1;   sr2   <= sr1;   sp2   <= sp1;

    a3    <= sr2 * spcy2;
    b3    <= cr2 * spcy2;
    c3    <= sr2 * spsy2;
    d3    <= cr2 * spsy2;
    cpcy3 <= cpcy2; cpsy3 <= cpsy2; srcp3 <= srcp2; crcp3 <= crcp2;
    crsy3 <= crsy2; srsy3 <= srsy2; crcy3 <= crcy2; srcy3 <= srcy2;
    sp3   <= sp2;

    result.m00 <= eatrm_pkg::to_q14(SW'(cpcy3));
    result.m01 <= eatrm_pkg::to_q14(SW'(a3) - SW'(crsy3));
    result.m02 <= eatrm_pkg::to_q14(SW'(srsy3) + SW'(b3));
    result.m10 <= eatrm_pkg::to_q14(SW'(cpsy3));
    result.m11 <= eatrm_pkg::to_q14(SW'(crcy3) + SW'(c3));
    result.m12 <= eatrm_pkg::to_q14(SW'(d3) - SW'(srcy3));
    result.m20 <= eatrm_pkg::to_q14(SW'(0) - (SW'(sp3) <<< 24));
    result.m21 <= eatrm_pkg::to_q14(SW'(srcp3));
    result.m22 <= eatrm_pkg::to_q14(SW'(crcp3));
  end

  a_vld_latency: assert property (@(posedge clk) disable iff (rst)
    in_vld |-> ##4 done) else $error("matrix valid lost in pipeline");
  a_m20_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.m20 <= 16'sd16384 && result.m20 >= -16'sd16384))
    else $error("m20 outside Q1.14 unit range");
  a_m00_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.m00 <= 16'sd16384 && result.m00 >= -16'sd16384))
    else $error("m00 outside Q1.14 unit range");

endmodule

>>> rtl/euler_angles_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_unit
// Roll/pitch/yaw binary angles to a Q1.14 direction cosine matrix.
// ----------------------------------------------------------------------------
// Usage:
//  - operand carries roll, pitch and yaw (16-bit binary angles, 32768 = pi).
//    A transfer happens at any rising edge with start high and busy low.
//  - busy is held low: the pipeline takes a new item every cycle.
//  - result carries the nine matrix entries in Q1.14, saturated to +/-16384.
//    done marks it for exactly one cycle; the receiver cannot stall, so no
//    back-pressure exists and nothing is ever held.
//  - Pipeline: 18 CORDIC iteration stages, 1 rounding stage and 4 product,
//    round, triple-product and sum/saturate stages lie between the
//    accepting edge and the result; done rises with the result and holds
//    for one cycle.
//  - Throughput: one item per cycle, set by the fully pipelined CORDIC and
//    multiplier stages.
//  - Reset (rst, synchronous) clears the valid chain; items in flight are
//    dropped and done stays low until fresh items emerge.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  eatrm_pkg::in_t   operand,
  output logic             done,
  output eatrm_pkg::out_t  result
);

  localparam int CDEPTH = eatrm_pkg::ITER_COUNT + 1;

  eatrm_pkg::trig_t roll_trig, pitch_trig, yaw_trig;
  logic [CDEPTH-1:0] cvld;

  // no stall source anywhere downstream
  assign busy = 1'b0;

  // valid bits follow the CORDIC stages
  always_ff @(posedge clk) begin
    if (rst) begin
      cvld <= '0;
    end else begin
      cvld <= {cvld[CDEPTH-2:0], start & ~busy};
    end
  end

  eatrm_cordic u_roll  (.clk(clk), .angle(operand.roll_angle),  .trig(roll_trig));
  eatrm_cordic u_pitch (.clk(clk), .angle(operand.pitch_angle), .trig(pitch_trig));
  eatrm_cordic u_yaw   (.clk(clk), .angle(operand.yaw_angle),   .trig(yaw_trig));

  eatrm_matrix u_matrix (
    .clk    (clk),
    .rst    (rst),
    .in_vld (cvld[CDEPTH-1]),
    .roll   (roll_trig),
    .pitch  (pitch_trig),
    .yaw    (yaw_trig),
    .done   (done),
    .result (result)
  );

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_done_from_cordic: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cvld[CDEPTH-1], 4)) else $error("done without transfer");
  a_m22_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.m22 <= 16'sd16384 && result.m22 >= -16'sd16384))
    else $error("m22 outside Q1.14 unit range");

endmodule
